@@ src/sab_pkg.sv @@
// shared constants, codes and structs of the slot allocator
package sab_pkg;

  // store geometry
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // fixed field widths of the channels
  localparam int OP_FW   = 3;
  localparam int IDX_FW  = 6;
  localparam int DATA_FW = 32;
  localparam int STAT_FW = 2;
  localparam int CNT_FW  = 7;

  // operation codes
  typedef enum logic [OP_FW-1:0] {
    OP_ADD       = 3'd0,
    OP_ADD_AT    = 3'd1,
    OP_SET_USED  = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_GET       = 3'd4,
    OP_GET_USED  = 3'd5,
    OP_NEXT_USED = 3'd6,
    OP_FIND_FREE = 3'd7
  } sab_op_t;

  // result status codes
  typedef enum logic [STAT_FW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } sab_status_t;

  // decision made by the bitmap for one operation
  typedef struct packed {
    sab_status_t       status;
    logic [IDX_FW-1:0] found_index;
    logic [CNT_FW-1:0] next_start;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
  } sab_dec_t;

  // bookkeeping counters
  typedef struct packed {
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] high_water;
  } sab_cnt_t;

endpackage

@@ src/sab_in_if.sv @@
// operation channel of the slot allocator
interface sab_in_if import sab_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_FW-1:0]    op;
  logic [IDX_FW-1:0]   slot_index;
  logic [DATA_FW-1:0]  write_data;

  modport source (output valid, output op, output slot_index, output write_data,
                  input ready);
  modport sink   (input valid, input op, input slot_index, input write_data,
                  output ready);
endinterface

@@ src/sab_out_if.sv @@
// result channel of the slot allocator
interface sab_out_if import sab_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_FW-1:0]  status;
  logic [IDX_FW-1:0]   found_index;
  logic [DATA_FW-1:0]  read_data;
  logic [CNT_FW-1:0]   next_start;
  logic [CNT_FW-1:0]   used_count;
  logic [CNT_FW-1:0]   high_water;

  modport source (output valid, output status, output found_index, output read_data,
                  output next_start, output used_count, output high_water,
                  input ready);
  modport sink   (input valid, input status, input found_index, input read_data,
                  input next_start, input used_count, input high_water,
                  output ready);
endinterface

@@ src/sab_ram.sv @@
// simple dual-port ram with registered read data
module sab_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/sab_bitmap.sv @@
// used bitmap, counters and priority encoders of the slot allocator
module sab_bitmap import sab_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              exec,
  input  sab_op_t           op,
  input  logic [IDX_FW-1:0] slot_index,
  output sab_dec_t          dec,
  output sab_cnt_t          cnt
);

  logic [CAPACITY-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    top_r, top_nxt;

  logic [31:0]         idx_wide;
  logic                in_range;
  logic [SLOT_W-1:0]   slot;
  logic [CNT_W-1:0]    slot_cnt;
  logic [CNT_W-1:0]    slot_plus1;

  logic                ff_found;
  logic [SLOT_W-1:0]   ff_idx;
  logic                nu_found;
  logic [SLOT_W-1:0]   nu_idx;
  logic                hi_found;
  logic [SLOT_W-1:0]   hi_idx;
  logic [CAPACITY-1:0] used_clr;

  assign idx_wide   = 32'(slot_index);
  assign in_range   = idx_wide < 32'(CAPACITY);
  assign slot       = SLOT_W'(slot_index);
  assign slot_cnt   = CNT_W'(slot);
  assign slot_plus1 = slot_cnt + CNT_W'(1);

  // first free slot, lowest index wins
  always_comb begin
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        ff_found = 1'b1;
        ff_idx   = SLOT_W'(i);
      end
    end
  end

  // first used slot in [slot, top)
  always_comb begin
    nu_found = 1'b0;
    nu_idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (used_r[i] && (CNT_W'(i) >= slot_cnt) && (CNT_W'(i) < top_r)) begin
        nu_found = 1'b1;
        nu_idx   = SLOT_W'(i);
      end
    end
  end

  // highest used slot once the addressed one is freed
  always_comb begin
    used_clr       = used_r;
    used_clr[slot] = 1'b0;
    hi_found       = 1'b0;
    hi_idx         = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (used_clr[i]) begin
        hi_found = 1'b1;
        hi_idx   = SLOT_W'(i);
      end
    end
  end

  // operation decode and next state
  always_comb begin
    used_nxt        = used_r;
    cnt_nxt         = cnt_r;
    top_nxt         = top_r;
    dec.status      = ST_OK;
    dec.found_index = slot_index;
    dec.next_start  = '0;
    dec.rd_en       = 1'b0;
    dec.rd_addr     = slot;
    dec.wr_en       = 1'b0;
    dec.wr_addr     = slot;
    unique case (op) inside
      OP_ADD, OP_FIND_FREE: begin
        if ((cnt_r >= CNT_W'(CAPACITY)) || !ff_found) begin
          dec.status      = ST_FULL;
          dec.found_index = '0;
        end else begin
          dec.found_index = IDX_FW'(ff_idx);
          if (op == OP_ADD) begin
            dec.wr_en        = 1'b1;
            dec.wr_addr      = ff_idx;
            used_nxt[ff_idx] = 1'b1;
            cnt_nxt          = cnt_r + CNT_W'(1);
            if (top_r <= CNT_W'(ff_idx)) begin
              top_nxt = CNT_W'(ff_idx) + CNT_W'(1);
            end
          end
        end
      end
      OP_ADD_AT, OP_SET_USED: begin
        if (!in_range) begin
          dec.status = ST_RANGE;
        end else if ((op == OP_SET_USED) && used_r[slot]) begin
          dec.status = ST_MISS;
        end else begin
          dec.wr_en = (op == OP_ADD_AT);
          if (!used_r[slot]) begin
            used_nxt[slot] = 1'b1;
            cnt_nxt        = cnt_r + CNT_W'(1);
          end
          if (top_r <= slot_cnt) begin
            top_nxt = slot_plus1;
          end
        end
      end
      OP_REMOVE: begin
        if (!in_range) begin
          dec.status = ST_RANGE;
        end else if (!used_r[slot]) begin
          dec.status = ST_MISS;
        end else begin
          used_nxt[slot] = 1'b0;
          cnt_nxt        = cnt_r - CNT_W'(1);
          if (top_r == slot_plus1) begin
            top_nxt = hi_found ? (CNT_W'(hi_idx) + CNT_W'(1)) : '0;
          end
        end
      end
      OP_GET: begin
        if (!in_range) begin
          dec.status = ST_RANGE;
        end else begin
          dec.rd_en = 1'b1;
        end
      end
      OP_GET_USED: begin
        if (!in_range) begin
          dec.status = ST_RANGE;
        end else if ((slot_cnt >= top_r) || !used_r[slot]) begin
          dec.status = ST_MISS;
        end else begin
          dec.rd_en = 1'b1;
        end
      end
      OP_NEXT_USED: begin
        if (!in_range) begin
          dec.status = ST_RANGE;
        end else if (slot_cnt >= top_r) begin
          dec.status     = ST_MISS;
          dec.next_start = CNT_FW'(slot_index);
        end else if (nu_found) begin
          dec.found_index = IDX_FW'(nu_idx);
          dec.rd_en       = 1'b1;
          dec.rd_addr     = nu_idx;
          dec.next_start  = CNT_FW'(CNT_W'(nu_idx) + CNT_W'(1));
        end else begin
          dec.status     = ST_MISS;
          dec.next_start = CNT_FW'(top_r);
        end
      end
      default: begin
        dec.status = ST_MISS;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      cnt_r  <= '0;
      top_r  <= '0;
    end else if (exec) begin
      used_r <= used_nxt;
      cnt_r  <= cnt_nxt;
      top_r  <= top_nxt;
    end
  end

  assign cnt.used_count = cnt_r;
  assign cnt.high_water = top_r;

  // count always matches the bitmap
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(used_r)))
    else $error("used count differs from bitmap population");

  // slot just below the mark is used
  a_top_used: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r == '0) || used_r[SLOT_W'(top_r - CNT_W'(1))])
    else $error("high-water mark above a free slot");

  // nothing used at or above the mark
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r >> top_r) == '0)
    else $error("used slot at or above high-water mark");

endmodule

@@ src/slot_allocator_bitmap.sv @@
// top level of the first-fit slot allocator
//
// One beat on in_bus is one operation (add, add-at, set-used, remove, get,
// get-used, next-used, find-free); each gives exactly one beat on out_bus
// with status, chosen slot, read data, next start, used count and mark.
// Both channels are valid/ready; a beat moves when both are high.
//
// In the accept cycle of an operation the bitmap and its priority
// encoders decide the operation, update the used bits and counters and
// start the data memory access; in the response state, once the result
// register is free, the registered memory read lands in it. A new
// operation is taken only once the last one has left the response state.
//
// The result register parts the two sides: while a result waits on a
// stalled receiver the next operation is still taken; the one after that
// waits until the pending result can move into the result register.
//
// Reset clears the used bitmap, the written flags and both counters in the
// same cycle, so the store reads as all zero right away with no clearing
// pass; the block takes operations in the first cycle after reset.
module slot_allocator_bitmap import sab_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sab_in_if.sink    in_bus,
  sab_out_if.source out_bus
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  state_t              state_r;
  logic                out_valid_r;
  sab_status_t         status_r;
  logic [IDX_FW-1:0]   found_r;
  logic [DATA_FW-1:0]  rdata_r;
  logic [CNT_FW-1:0]   nstart_r;
  logic [CNT_FW-1:0]   ucount_r;
  logic [CNT_FW-1:0]   hwater_r;
  sab_dec_t            pend_r;
  logic                rd_ok_r;
  logic [CAPACITY-1:0] written_r;

  logic                in_fire;
  logic                out_fire;
  logic                out_free;
  sab_dec_t            dec;
  sab_cnt_t            cnt;
  logic [DATA_WIDTH-1:0] ram_q;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_fire     = out_valid_r && out_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;

  // bitmap and counters
  sab_bitmap u_bitmap (
    .clk        (clk),
    .rst_n      (rst_n),
    .exec       (in_fire),
    .op         (sab_op_t'(in_bus.op)),
    .slot_index (in_bus.slot_index),
    .dec        (dec),
    .cnt        (cnt)
  );

  // slot payload memory
  sab_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (in_fire && dec.wr_en),
    .waddr (dec.wr_addr),
    .wdata (DATA_WIDTH'(in_bus.write_data)),
    .re    (in_fire && dec.rd_en),
    .raddr (dec.rd_addr),
    .rdata (ram_q)
  );

  // written flags, a never written slot reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (in_fire && dec.wr_en) begin
      written_r[dec.wr_addr] <= 1'b1;
    end
  end

  // decision held for the response cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_r  <= dec;
      rd_ok_r <= dec.rd_en && written_r[dec.rd_addr];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_fire) begin
            out_valid_r <= 1'b0;
          end
          if (in_fire) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            status_r    <= pend_r.status;
            found_r     <= pend_r.found_index;
            rdata_r     <= rd_ok_r ? DATA_FW'(ram_q) : '0;
            nstart_r    <= pend_r.next_start;
            ucount_r    <= CNT_FW'(cnt.used_count);
            hwater_r    <= CNT_FW'(cnt.high_water);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.status      = status_r;
  assign out_bus.found_index = found_r;
  assign out_bus.read_data   = rdata_r;
  assign out_bus.next_start  = nstart_r;
  assign out_bus.used_count  = ucount_r;
  assign out_bus.high_water  = hwater_r;

  // an accepted beat always goes through the response cycle
  a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_RESP))
    else $error("accepted beat skipped the response cycle");

  // a pending result waits while the result register is still occupied
  a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && !out_free |=> (state_r == S_RESP) && out_valid_r)
    else $error("pending result dropped under stall");

  // leaving the response cycle always presents a result
  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && out_free |=> out_valid_r)
    else $error("response cycle ended without a result");

endmodule
